// ===== design/bale_pkg.sv =====
// ----------------------------------------------------------------------------
// bale_pkg
// Shared types and constants for the bounded array list engine: operation
// and status codes, sequencer states and the result record.
// ----------------------------------------------------------------------------
package bale_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int DATA_W       = 32;
	localparam int OP_W         = 3;
	localparam int POS_W        = 5;
	localparam int AMT_W        = 8;
	localparam int ST_W         = 3;
	localparam int FOUND_W      = 4;
	localparam int LEN_W        = 5;

	typedef enum logic [OP_W-1:0] {
		OP_INS_FRONT = 3'd0,
		OP_INS_BACK  = 3'd1,
		OP_INS_AT    = 3'd2,
		OP_DEL_FRONT = 3'd3,
		OP_DEL_BACK  = 3'd4,
		OP_DEL_AT    = 3'd5,
		OP_SEARCH    = 3'd6,
		OP_ROTATE    = 3'd7
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_BADPOS   = 3'd3,
		ST_NOTFOUND = 3'd4,
		ST_SHORT    = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		SQ_IDLE,
		SQ_DIV,
		SQ_RUN,
		SQ_DRAIN,
		SQ_PUT,
		SQ_DONE
	} seq_state_t;

	typedef struct packed {
		status_t             status;
		logic [DATA_W-1:0]   removed_value;
		logic [FOUND_W-1:0]  found_position;
		logic [LEN_W-1:0]    length;
	} res_t;

endpackage

// ===== design/bale_ram.sv =====
// ----------------------------------------------------------------------------
// bale_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module bale_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/bale_rem.sv =====
// ----------------------------------------------------------------------------
// bale_rem
// Restoring remainder unit: one dividend bit per cycle, done pulses with the
// remainder held until the next start.
// ----------------------------------------------------------------------------
module bale_rem #(
	parameter int NUM_W = 8,
	parameter int DEN_W = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [DEN_W-1:0] rem
);

	localparam int CNT_W = $clog2(NUM_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic [DEN_W-1:0] rem_nx;

	assign trial  = {rem_q, num_q[NUM_W-1]};
	assign diff   = trial - {1'b0, den_q};
	assign rem_nx = (trial >= {1'b0, den_q}) ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && (cnt_q == '0)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			cnt_q <= CNT_W'(NUM_W - 1);
		end else if (busy_q) begin
			num_q <= num_q << 1;
			rem_q <= rem_nx;
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

// ===== design/bale_seq.sv =====
// ----------------------------------------------------------------------------
// bale_seq
// Operation sequencer: decodes an item, walks the element store one entry
// per cycle through a read-then-write pipeline and builds the result.
// ----------------------------------------------------------------------------
module bale_seq #(
	parameter int CAPACITY = bale_pkg::CAPACITY_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [bale_pkg::OP_W-1:0]         operation,
	input  logic signed [bale_pkg::DATA_W-1:0] value,
	input  logic [bale_pkg::POS_W-1:0]        position,
	output logic                              res_valid,
	input  logic                              res_ready,
	output bale_pkg::res_t                    res,
	output logic [$clog2(CAPACITY)-1:0]       ram_raddr,
	input  logic [bale_pkg::DATA_W-1:0]       ram_rdata0,
	input  logic [bale_pkg::DATA_W-1:0]       ram_rdata1,
	output logic                              ram_we0,
	output logic                              ram_we1,
	output logic [$clog2(CAPACITY)-1:0]       ram_waddr,
	output logic [bale_pkg::DATA_W-1:0]       ram_wdata,
	output logic                              rem_start,
	output logic [$clog2(CAPACITY+1)-1:0]     rem_divisor,
	input  logic                              rem_done,
	input  logic [$clog2(CAPACITY+1)-1:0]     rem_value
);

	import bale_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > POS_W) ? CW : POS_W;

	seq_state_t        state_q, state_d;
	op_t               op_q, op_in;
	logic [DATA_W-1:0] val_q;
	logic [AW-1:0]     idx_q, rd_q, end_q, addr_s1, wptr_q, wptr_nx;
	logic              vld_s1;
	logic [CW-1:0]     count_q;
	logic              bank_q;
	status_t           status_q;
	logic [DATA_W-1:0] removed_q;
	logic [FOUND_W-1:0] found_q;

	logic              accept, is_ins, proc, match, we_act, we_oth;
	logic              full, empty;
	logic [XW-1:0]     posx, cntx;
	logic [DATA_W-1:0] rdata;
	seq_state_t        dec_next;
	status_t           dec_status;
	logic [AW-1:0]     dec_idx, dec_rd, dec_end;

	assign op_in   = op_t'(operation);
	assign accept  = in_valid && (state_q == SQ_IDLE);
	assign rdata   = bank_q ? ram_rdata1 : ram_rdata0;
	assign is_ins  = (op_q == OP_INS_FRONT) || (op_q == OP_INS_BACK) || (op_q == OP_INS_AT);
	assign proc    = vld_s1 && ((state_q == SQ_RUN) || (state_q == SQ_DRAIN));
	assign match   = proc && (op_q == OP_SEARCH) && (rdata == val_q);
	assign full    = (count_q == CW'(CAPACITY));
	assign empty   = (count_q == '0);
	assign posx    = XW'(position);
	assign cntx    = XW'(count_q);
	assign wptr_nx = ((CW'(wptr_q) + CW'(1)) == count_q) ? '0 : wptr_q + 1'b1;

	// item decode
	always_comb begin
		dec_next   = SQ_DONE;
		dec_status = ST_OK;
		dec_idx    = '0;
		dec_rd     = '0;
		dec_end    = AW'(count_q - 1'b1);
		unique case (op_in) inside
			OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
				dec_idx = (op_in == OP_INS_FRONT) ? '0 :
				          (op_in == OP_INS_BACK) ? AW'(count_q) : AW'(position);
				dec_rd  = AW'(count_q - 1'b1);
				dec_end = dec_idx;
				if ((op_in == OP_INS_AT) && (posx > cntx)) begin
					dec_status = ST_BADPOS;
				end else if (full) begin
					dec_status = ST_FULL;
				end else if (CW'(dec_idx) < count_q) begin
					dec_next = SQ_RUN;
				end else begin
					dec_next = SQ_PUT;
				end
			end
			OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT: begin
				dec_idx = (op_in == OP_DEL_FRONT) ? '0 :
				          (op_in == OP_DEL_BACK) ? AW'(count_q - 1'b1) : AW'(position);
				dec_rd  = dec_idx;
				if ((op_in == OP_DEL_AT) && (posx >= cntx)) begin
					dec_status = ST_BADPOS;
				end else if (empty) begin
					dec_status = ST_EMPTY;
				end else begin
					dec_next = SQ_RUN;
				end
			end
			OP_SEARCH: begin
				dec_status = ST_NOTFOUND;
				if (!empty) begin
					dec_next = SQ_RUN;
				end
			end
			OP_ROTATE: begin
				if (count_q < CW'(2)) begin
					dec_status = ST_SHORT;
				end else begin
					dec_next = SQ_DIV;
				end
			end
			default: begin
				dec_next = SQ_DONE;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SQ_IDLE: begin
				if (accept) begin
					state_d = dec_next;
				end
			end
			SQ_DIV: begin
				if (rem_done) begin
					state_d = SQ_RUN;
				end
			end
			SQ_RUN: begin
				if (match) begin
					state_d = SQ_DONE;
				end else if (rd_q == end_q) begin
					state_d = SQ_DRAIN;
				end
			end
			SQ_DRAIN: begin
				state_d = is_ins ? SQ_PUT : SQ_DONE;
			end
			SQ_PUT: begin
				state_d = SQ_DONE;
			end
			SQ_DONE: begin
				if (res_ready) begin
					state_d = SQ_IDLE;
				end
			end
			default: begin
				state_d = SQ_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		in_stall  = 1'b1;
		res_valid = 1'b0;
		we_act    = 1'b0;
		we_oth    = 1'b0;
		ram_waddr = '0;
		ram_wdata = rdata;
		unique case (state_q)
			SQ_IDLE: begin
				in_stall = 1'b0;
			end
			SQ_DIV: begin
			end
			SQ_RUN, SQ_DRAIN: begin
				if (vld_s1) begin
					case (op_q) inside
						OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
							we_act    = 1'b1;
							ram_waddr = addr_s1 + 1'b1;
						end
						OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT: begin
							we_act    = (addr_s1 != idx_q);
							ram_waddr = addr_s1 - 1'b1;
						end
						OP_ROTATE: begin
							we_oth    = 1'b1;
							ram_waddr = wptr_q;
						end
						default: begin
						end
					endcase
				end
			end
			SQ_PUT: begin
				we_act    = 1'b1;
				ram_waddr = idx_q;
				ram_wdata = val_q;
			end
			SQ_DONE: begin
				res_valid = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign ram_we0     = (we_act && !bank_q) || (we_oth && bank_q);
	assign ram_we1     = (we_act && bank_q) || (we_oth && !bank_q);
	assign ram_raddr   = rd_q;
	assign rem_start   = accept && (dec_next == SQ_DIV);
	assign rem_divisor = count_q;

	assign res.status         = status_q;
	assign res.removed_value  = removed_q;
	assign res.found_position = found_q;
	assign res.length         = LEN_W'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			count_q <= '0;
			bank_q  <= 1'b0;
			vld_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= (state_q == SQ_RUN);
			if (state_q == SQ_PUT) begin
				count_q <= count_q + 1'b1;
			end
			if ((state_q == SQ_DRAIN) && !is_ins && (op_q != OP_SEARCH)) begin
				if (op_q == OP_ROTATE) begin
					bank_q <= !bank_q;
				end else begin
					count_q <= count_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= rd_q;
		if (accept) begin
			op_q      <= op_in;
			val_q     <= value;
			idx_q     <= dec_idx;
			rd_q      <= dec_rd;
			end_q     <= dec_end;
			status_q  <= dec_status;
			removed_q <= '0;
			found_q   <= '0;
			wptr_q    <= '0;
		end else begin
			if ((state_q == SQ_DIV) && rem_done) begin
				wptr_q <= AW'(rem_value);
			end
			if ((state_q == SQ_RUN) && (rd_q != end_q)) begin
				rd_q <= is_ins ? rd_q - 1'b1 : rd_q + 1'b1;
			end
			if (proc) begin
				case (op_q) inside
					OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT: begin
						if (addr_s1 == idx_q) begin
							removed_q <= rdata;
						end
					end
					OP_SEARCH: begin
						if (match && (status_q == ST_NOTFOUND)) begin
							status_q <= ST_OK;
							found_q  <= FOUND_W'(addr_s1);
						end
					end
					OP_ROTATE: begin
						wptr_q <= wptr_nx;
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

// ===== design/bounded_array_list_engine_top.sv =====
// ----------------------------------------------------------------------------
// bounded_array_list_engine_top
// Ordered list of signed 32-bit elements with insert, delete, search and
// rotate, kept in two banked element RAMs with a result register at the output.
//
//   channel  direction  handshake             fields
//   in       input      in_valid / in_stall   operation value position rotate_amount
//   out      output     out_valid / out_stall status removed_value found_position length
//
// One item at a time. An error result is ready in the cycle after acceptance;
// shifts and searches walk one element per cycle through the RAM read/write
// port; a rotate first runs the remainder unit and then copies every element
// into the other bank. Reset clears the count, bank select and control state;
// the element RAMs are not cleared. in_stall stays high from acceptance until
// the result enters the output register, which holds it while out_stall is high.
// ----------------------------------------------------------------------------
module bounded_array_list_engine_top #(
	parameter int CAPACITY = bale_pkg::CAPACITY_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [bale_pkg::OP_W-1:0]          operation,
	input  logic signed [bale_pkg::DATA_W-1:0] value,
	input  logic [bale_pkg::POS_W-1:0]         position,
	input  logic [bale_pkg::AMT_W-1:0]         rotate_amount,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [bale_pkg::ST_W-1:0]          status,
	output logic signed [bale_pkg::DATA_W-1:0] removed_value,
	output logic [bale_pkg::FOUND_W-1:0]       found_position,
	output logic [bale_pkg::LEN_W-1:0]         length
);

	import bale_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic              res_valid, res_ready, load;
	res_t              res, out_res_q;
	logic              out_vld_q;
	logic [AW-1:0]     ram_raddr, ram_waddr;
	logic [DATA_W-1:0] ram_rdata0, ram_rdata1, ram_wdata;
	logic              ram_we0, ram_we1;
	logic              rem_start, rem_done;
	logic [CW-1:0]     rem_divisor, rem_value;

	bale_seq #(
		.CAPACITY (CAPACITY)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.operation   (operation),
		.value       (value),
		.position    (position),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res),
		.ram_raddr   (ram_raddr),
		.ram_rdata0  (ram_rdata0),
		.ram_rdata1  (ram_rdata1),
		.ram_we0     (ram_we0),
		.ram_we1     (ram_we1),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.rem_start   (rem_start),
		.rem_divisor (rem_divisor),
		.rem_done    (rem_done),
		.rem_value   (rem_value)
	);

	bale_ram #(
		.WIDTH (DATA_W),
		.DEPTH (CAPACITY)
	) u_bank0 (
		.clk   (clk),
		.we    (ram_we0),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata0)
	);

	bale_ram #(
		.WIDTH (DATA_W),
		.DEPTH (CAPACITY)
	) u_bank1 (
		.clk   (clk),
		.we    (ram_we1),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata1)
	);

	bale_rem #(
		.NUM_W (AMT_W),
		.DEN_W (CW)
	) u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rem_start),
		.num    (rotate_amount),
		.den    (rem_divisor),
		.done   (rem_done),
		.rem    (rem_value)
	);

	// output item register
	assign res_ready = !out_vld_q || !out_stall;
	assign load      = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_res_q <= res;
		end
	end

	assign out_valid      = out_vld_q;
	assign status         = out_res_q.status;
	assign removed_value  = out_res_q.removed_value;
	assign found_position = out_res_q.found_position;
	assign length         = out_res_q.length;

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !(ram_we0 || ram_we1))
		else $error("element store written while idle");

	a_one_bank: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we0 && ram_we1))
		else $error("both banks written in one cycle");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("accepted item did not start work");

	a_rem_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rem_done |-> in_stall)
		else $error("remainder finished outside a rotate");

endmodule
